// ===== design/sulv_pkg.sv =====
// sulv_pkg: shared types and codes of the sorted unique value list
// no dependencies
`default_nettype none

package sulv_pkg;

    localparam int ValueW = 32;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_REVERSE = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_ENTRY    = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    // one entry as it travels between neighboring cells
    typedef struct packed {
        logic                     valid;
        logic signed [ValueW-1:0] value;
    } t_link;

    // command broadcast to every cell, at most one bit set
    typedef struct packed {
        logic ins;
        logic rem;
        logic rot_up;
        logic rot_dn;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== design/sulv_cell.sv =====
// sulv_cell: one slot of the descending chain, compares against the broadcast value
// and shifts with its neighbors; depends on sulv_pkg
`default_nettype none

module sulv_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire sulv_pkg::t_cell_cmd              i_cmd,
    input  wire logic signed [sulv_pkg::ValueW-1:0] i_x,
    input  wire logic signed [sulv_pkg::ValueW-1:0] i_wrap,
    input  wire sulv_pkg::t_link                  i_prev,
    input  wire logic                             i_prev_gt,
    input  wire sulv_pkg::t_link                  i_next,
    output sulv_pkg::t_link                       o_link,
    output logic                                  o_gt,
    output logic                                  o_eq
);
    import sulv_pkg::*;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [ValueW-1:0] r_value;
    logic signed [ValueW-1:0] n_value;

    assign o_gt   = r_valid && (r_value > i_x);
    assign o_eq   = r_valid && (r_value == i_x);
    assign o_link = '{valid: r_valid, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        priority if (i_cmd.ins && !o_gt) begin
            if (i_prev_gt) begin
                n_valid = 1'b1;
                n_value = i_x;
            end else begin
                n_valid = i_prev.valid;
                n_value = i_prev.value;
            end
        end else if (i_cmd.rem && !o_gt) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end else if (i_cmd.rot_up) begin
            n_value = i_prev.valid ? i_prev.value : i_wrap;
        end else if (i_cmd.rot_dn) begin
            n_value = i_next.valid ? i_next.value : i_wrap;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// ===== design/sorted_unique_value_list.sv =====
// sorted_unique_value_list: top level, chain of sulv_cell slots plus request control
// depends on sulv_pkg and sulv_cell
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_req_type, i_item_value
//   out      output     o_out_valid / i_out_ready o_out_value, o_status, o_last
//
// insert and remove act on all cells at once: every cell compares and shifts together;
// reverse only flips the read direction. a read out gives each stored entry, rotating
// the chain one slot per result, so the chain is back in place after the last one.
// a request enters only in idle with the output register empty or drained that cycle;
// a held result stalls both the input and the read out.
// reset clears every valid bit, the count and the direction; entry values are not reset.
`default_nettype none

module sorted_unique_value_list #(
    parameter int CAPACITY = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_req_type,
    input  wire logic signed [sulv_pkg::ValueW-1:0] i_item_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [sulv_pkg::ValueW-1:0]      o_out_value,
    output logic [2:0]                              o_status,
    output logic                                    o_last
);
    import sulv_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_left;
    logic [CW-1:0]            n_left;
    logic                     r_asc;
    logic                     n_asc;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [ValueW-1:0] r_out_value;
    logic signed [ValueW-1:0] n_out_value;
    t_status                  r_status;
    t_status                  n_status;
    logic                     r_last;
    logic                     n_last;

    t_link                    w_link [CAPACITY];
    t_link                    w_prev [CAPACITY];
    t_link                    w_next [CAPACITY];
    logic [CAPACITY-1:0]      w_gt;
    logic [CAPACITY-1:0]      w_prev_gt;
    logic [CAPACITY-1:0]      w_eq;
    logic [CAPACITY-1:0]      w_valid;
    logic signed [ValueW-1:0] w_tail;
    logic signed [ValueW-1:0] w_wrap;
    t_cell_cmd                w_cmd;
    logic                     w_slot_free;
    logic                     w_accept;
    logic                     w_any_eq;
    logic                     w_full;
    t_req                     w_req;

    assign w_req       = t_req'(i_req_type);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_any_eq    = |w_eq;
    assign w_full      = (r_count == CW'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_valid[g] = w_link[g].valid;
            if (g == 0) begin : g_head
                assign w_prev[g]    = '{valid: 1'b0, value: '0};
                assign w_prev_gt[g] = 1'b1;
            end else begin : g_body
                assign w_prev[g]    = w_link[g-1];
                assign w_prev_gt[g] = w_gt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign w_next[g] = '{valid: 1'b0, value: '0};
            end else begin : g_mid
                assign w_next[g] = w_link[g+1];
            end
            sulv_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_x       (i_item_value),
                .i_wrap    (w_wrap),
                .i_prev    (w_prev[g]),
                .i_prev_gt (w_prev_gt[g]),
                .i_next    (w_next[g]),
                .o_link    (w_link[g]),
                .o_gt      (w_gt[g]),
                .o_eq      (w_eq[g])
            );
        end
    endgenerate

    // value of the last valid slot, the smallest entry
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_valid[i] && (i == CAPACITY - 1 || !w_next[i].valid)) begin
                w_tail = w_tail | w_link[i].value;
            end
        end
    end

    assign w_wrap = r_asc ? w_tail : w_link[0].value;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_asc       = r_asc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_status    = r_status;
        n_last      = r_last;
        w_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_value = '0;
                    n_last      = 1'b1;
                    n_out_valid = 1'b1;
                    unique case (w_req)
                        REQ_INSERT: begin
                            if (w_any_eq) begin
                                n_status = ST_DUP;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.ins = 1'b1;
                                n_count   = r_count + CW'(1);
                                n_status  = ST_DONE;
                            end
                        end
                        REQ_REMOVE: begin
                            if (w_any_eq) begin
                                w_cmd.rem = 1'b1;
                                n_count   = r_count - CW'(1);
                                n_status  = ST_DONE;
                            end else begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                        REQ_REVERSE: begin
                            n_asc    = !r_asc;
                            n_status = ST_DONE;
                        end
                        REQ_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_left      = r_count;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = w_wrap;
                    n_status     = ST_ENTRY;
                    n_last       = (r_left == CW'(1));
                    n_left       = r_left - CW'(1);
                    w_cmd.rot_up = r_asc;
                    w_cmd.rot_dn = !r_asc;
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_asc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_asc       <= n_asc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("valid slots disagree with entry count");

    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left != '0 && r_left <= r_count))
        else $error("read out counter out of range");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == REQ_INSERT && !w_any_eq && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_sorted_unique_value_list.sv =====
// tb_sorted_unique_value_list: self-checking testbench with a scoreboard class that predicts
// every status and read-out transaction of the sorted list under random stalls on both sides
// depends on sulv_pkg and sorted_unique_value_list
`default_nettype none

module tb_sorted_unique_value_list;

    timeunit 1ns;
    timeprecision 1ps;

    import sulv_pkg::*;

    localparam int Capacity  = 32;
    localparam int PoolSize  = 48;
    localparam int FillItems = 60;
    localparam int MixItems  = 65;
    localparam int HoldOff   = 400;

    typedef logic signed [ValueW-1:0] t_value;

    typedef struct {
        t_value  value;
        t_status status;
        logic    last;
    } t_list_result;

    class list_scoreboard;
        t_list_result expected_q[$];
        t_value       stored_q[$];
        bit           ascending;
        int           errors;
        int           accepted;

        function void add_expected(t_value value, t_status status, logic last);
            t_list_result r;
            r.value  = value;
            r.status = status;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // predicts the results of one accepted request and updates the list copy
        function void note_request(t_req req, t_value val);
            int      pos;
            int      n;
            int      idx;
            t_status st;
            accepted++;
            n = stored_q.size();
            case (req)
                REQ_INSERT: begin
                    pos = 0;
                    st  = ST_DONE;
                    while (pos < n && stored_q[pos] >= val) begin
                        if (stored_q[pos] == val) begin
                            st = ST_DUP;
                            break;
                        end
                        pos++;
                    end
                    if (st == ST_DONE) begin
                        if (n >= Capacity) begin
                            st = ST_FULL;
                        end else begin
                            stored_q.insert(pos, val);
                        end
                    end
                    add_expected('0, st, 1'b1);
                end
                REQ_REMOVE: begin
                    st = ST_NOTFOUND;
                    for (pos = 0; pos < n; pos++) begin
                        if (stored_q[pos] == val) begin
                            st = ST_DONE;
                            break;
                        end
                    end
                    if (st == ST_DONE) stored_q.delete(pos);
                    add_expected('0, st, 1'b1);
                end
                REQ_REVERSE: begin
                    ascending = !ascending;
                    add_expected('0, ST_DONE, 1'b1);
                end
                default: begin
                    if (n == 0) begin
                        add_expected('0, ST_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            idx = ascending ? (n - 1 - i) : i;
                            add_expected(stored_q[idx], ST_ENTRY, (i == n - 1));
                        end
                    end
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_value value, logic [2:0] status, logic last);
            t_list_result r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction value=%0d status=%0d last=%0b",
                                 value, status, last));
            end else begin
                r = expected_q.pop_front();
                if (value !== r.value)
                    report($sformatf("out_value got %0d expected %0d", value, r.value));
                if (status !== r.status)
                    report($sformatf("status got %0d expected %s", status, r.status.name()));
                if (last !== r.last)
                    report($sformatf("last got %0b expected %0b", last, r.last));
            end
        endtask

        task final_check();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected transactions never arrived", expected_q.size()));
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    logic [1:0]   i_req_type;
    t_value       i_item_value;
    logic         o_out_valid;
    logic         i_out_ready;
    t_value       o_out_value;
    logic [2:0]   o_status;
    logic         o_last;

    list_scoreboard sb;
    t_value         value_pool[PoolSize];
    int             sent_count;
    int             rcv_count;
    bit             held;

    sorted_unique_value_list #(
        .CAPACITY(Capacity)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_item_value(i_item_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL sorted_unique_value_list");
        $finish;
    end

    function automatic int draw_gap(bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic t_req pick_req(bit fill_phase);
        int r;
        r = $urandom_range(0, 99);
        if (fill_phase) begin
            if (r < 75) return REQ_INSERT;
            if (r < 80) return REQ_REMOVE;
            if (r < 85) return REQ_REVERSE;
            return REQ_READ;
        end
        if (r < 35) return REQ_INSERT;
        if (r < 70) return REQ_REMOVE;
        if (r < 80) return REQ_REVERSE;
        return REQ_READ;
    endfunction

    function automatic t_value pick_value();
        if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, PoolSize - 1)];
        return t_value'($urandom);
    endfunction

    // valid stays high between back-to-back transactions, lowered only before a gap
    task automatic send_request(t_req req, t_value val);
        int g;
        g = draw_gap(((sent_count / 20) % 3) == 1);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_item_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req, val);
        sent_count++;
    endtask

    initial begin : drain
        int g;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && sb.accepted >= 30) begin
                held = 1'b1;
                g    = HoldOff;
            end else begin
                g = draw_gap(((rcv_count / 40) % 3) == 2);
            end
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_value, o_status, o_last);
            rcv_count++;
        end
    end

    initial begin : stimulus
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_INSERT;
        i_item_value = '0;
        i_out_ready  = 1'b0;
        for (int i = 0; i < PoolSize; i++)
            value_pool[i] = (i % 2) ? t_value'($urandom) : t_value'($urandom_range(0, 100) - 50);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_READ,    '0);
        send_request(REQ_REMOVE,  32'sd5);
        send_request(REQ_REVERSE, '0);
        send_request(REQ_READ,    '0);
        send_request(REQ_INSERT,  32'sh7FFF_FFFF);
        send_request(REQ_INSERT,  32'sh8000_0000);
        send_request(REQ_INSERT,  32'sd0);
        send_request(REQ_INSERT,  -32'sd1);
        send_request(REQ_INSERT,  32'sd1);
        send_request(REQ_INSERT,  32'sd0);
        send_request(REQ_INSERT,  32'sh8000_0000);
        send_request(REQ_READ,    '0);
        send_request(REQ_REVERSE, '0);
        send_request(REQ_READ,    32'shFFFF_FFFF);
        send_request(REQ_REMOVE,  32'sd2);
        send_request(REQ_REMOVE,  32'sh7FFF_FFFF);
        send_request(REQ_REMOVE,  32'sh8000_0000);
        send_request(REQ_REMOVE,  32'sd0);
        send_request(REQ_READ,    '0);
        send_request(REQ_REVERSE, 32'sh5A5A_A5A5);
        send_request(REQ_READ,    32'sh1234_5678);
        send_request(REQ_REMOVE,  -32'sd1);
        send_request(REQ_REMOVE,  32'sd1);
        send_request(REQ_READ,    '0);
        send_request(REQ_REVERSE, '0);

        // insert-heavy part fills the list, then a mixed part exercises full and drain
        for (int i = 0; i < FillItems; i++) send_request(pick_req(1'b1), pick_value());
        for (int i = 0; i < MixItems; i++) send_request(pick_req(1'b0), pick_value());
        i_in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        sb.final_check();
        if (sb.errors == 0) begin
            $display("PASS sorted_unique_value_list");
        end else begin
            $display("FAIL sorted_unique_value_list");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/sulv_pkg.sv
design/sulv_cell.sv
design/sorted_unique_value_list.sv
sim/tb_sorted_unique_value_list.sv
